// ===== design/bbs_pkg.sv =====
// Package for the bounded bag/stack block.
// Holds the action and status codes and the fixed widths of the channel fields.
// No dependencies.
package bbs_pkg;

  // Fixed widths of the beat fields.
  localparam int ActionW = 3;
  localparam int DataW   = 32;
  localparam int StatusW = 2;
  localparam int FillW   = 8;

  // Requested operation carried by an input beat.
  typedef enum logic [ActionW-1:0] {
    ActPush     = 3'd0,
    ActContains = 3'd1,
    ActRemove   = 3'd2,
    ActTop      = 3'd3,
    ActPop      = 3'd4
  } action_e;

  // Status reported with every result beat.
  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

endpackage

// ===== design/bbs_in_if.sv =====
// Input channel of the bounded bag/stack: valid/ready plus action and value.
// Depends on bbs_pkg for the field widths.
interface bbs_in_if;
  logic                              valid;
  logic                              ready;
  logic        [bbs_pkg::ActionW-1:0] action;
  logic signed [bbs_pkg::DataW-1:0]   value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

// ===== design/bbs_out_if.sv =====
// Result channel of the bounded bag/stack: valid/ready plus the result fields.
// Depends on bbs_pkg for the field widths.
interface bbs_out_if;
  logic                               valid;
  logic                               ready;
  logic        [bbs_pkg::StatusW-1:0] status;
  logic                               found;
  logic signed [bbs_pkg::DataW-1:0]   data;
  logic        [bbs_pkg::FillW-1:0]   fill_count;
  logic                               is_empty;

  modport source (output valid, output status, output found, output data,
                  output fill_count, output is_empty, input ready);
  modport sink   (input valid, input status, input found, input data,
                  input fill_count, input is_empty, output ready);
endinterface

// ===== design/bounded_bag_stack.sv =====
// Bounded bag/stack: CAPACITY entries of 32 bits held in one synchronous memory with one
// write port and one read port. Every input beat yields exactly one result beat. Push, pop,
// unknown actions and full/empty cases go from the execute state to the result state; top
// first passes a wait state for its read. Contains and remove walk the held entries through
// the memory read port one entry per cycle: remove scans up to the first match and
// then moves each later entry down one place, reading one entry and writing the one
// before it in the same cycle. One item is worked on at a time; a new beat is taken while
// the previous result still waits in the output register. The memory needs no clearing.
// Depends on bbs_pkg, bbs_in_if and bbs_out_if.
module bounded_bag_stack #(
  parameter int CAPACITY = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbs_in_if.sink    item_i,
  bbs_out_if.source result_o
);

  localparam int IdxW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int DataW = bbs_pkg::DataW;
  localparam int FillW = bbs_pkg::FillW;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StTopWait,
    StScan,
    StShift,
    StResp
  } state_e;

  state_e state_q;

  // Control state.
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] idx_q;
  logic            out_valid_q;

  // Item and pending result payload.
  logic [bbs_pkg::ActionW-1:0] act_q;
  logic [DataW-1:0]            val_q;
  bbs_pkg::status_e            res_status_q;
  logic                        res_found_q;
  logic [DataW-1:0]            res_data_q;

  // Output register payload.
  logic [bbs_pkg::StatusW-1:0] out_status_q;
  logic                        out_found_q;
  logic [DataW-1:0]            out_data_q;
  logic [FillW-1:0]            out_fill_q;
  logic                        out_empty_q;

  // Entry memory and its ports.
  logic [DataW-1:0] mem_q [CAPACITY];
  logic [DataW-1:0] rdata_q;
  logic             mem_re;
  logic [IdxW-1:0]  mem_raddr;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [DataW-1:0] mem_wdata;

  // Derived control values.
  logic [CntW-1:0] idx_nx;
  logic [CntW-1:0] count_m1;
  logic [IdxW-1:0] idx_nx_addr;
  logic [IdxW-1:0] idx_m1_addr;
  logic [IdxW-1:0] top_addr;
  logic [IdxW-1:0] tail_addr;
  logic            has_next;
  logic            is_full;
  logic            is_zero;
  logic            match;
  logic            out_free;
  logic            item_fire;

  assign idx_nx      = CntW'(idx_q) + CntW'(1);
  assign count_m1    = count_q - CntW'(1);
  assign idx_nx_addr = idx_nx[IdxW-1:0];
  assign idx_m1_addr = idx_q - IdxW'(1);
  assign top_addr    = count_m1[IdxW-1:0];
  assign tail_addr   = count_q[IdxW-1:0];
  assign has_next    = idx_nx < count_q;
  assign is_full     = count_q == CntW'(CAPACITY);
  assign is_zero     = count_q == '0;
  assign match       = rdata_q == val_q;
  assign out_free    = !out_valid_q || result_o.ready;

  assign item_i.ready = state_q == StIdle;
  assign item_fire    = item_i.valid && item_i.ready;

  // Memory port control for each phase of the work.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx_nx_addr;
    mem_we    = 1'b0;
    mem_waddr = tail_addr;
    mem_wdata = val_q;
    case (state_q)
      StExec: begin
        case (act_q)
          bbs_pkg::ActPush: begin
            mem_we = !is_full;
          end
          bbs_pkg::ActContains, bbs_pkg::ActRemove: begin
            mem_re    = !is_zero;
            mem_raddr = '0;
          end
          bbs_pkg::ActTop: begin
            mem_re    = !is_zero;
            mem_raddr = top_addr;
          end
          default: ;
        endcase
      end
      StScan: begin
        mem_re = has_next;
      end
      StShift: begin
        mem_we    = 1'b1;
        mem_waddr = idx_m1_addr;
        mem_wdata = rdata_q;
        mem_re    = has_next;
      end
      default: ;
    endcase
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Sequencer: state, fill count, scan index and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The output valid is set when a result is loaded and cleared when it is taken.
      if (state_q == StResp && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (item_fire) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          idx_q   <= '0;
          state_q <= StResp;
          case (act_q)
            bbs_pkg::ActPush: begin
              if (!is_full) begin
                count_q <= count_q + CntW'(1);
              end
            end
            bbs_pkg::ActContains, bbs_pkg::ActRemove: begin
              if (!is_zero) begin
                state_q <= StScan;
              end
            end
            bbs_pkg::ActTop: begin
              if (!is_zero) begin
                state_q <= StTopWait;
              end
            end
            bbs_pkg::ActPop: begin
              if (!is_zero) begin
                count_q <= count_m1;
              end
            end
            default: ;
          endcase
        end
        StTopWait: begin
          state_q <= StResp;
        end
        StScan: begin
          if (match) begin
            if (act_q == bbs_pkg::ActRemove && has_next) begin
              idx_q   <= idx_nx_addr;
              state_q <= StShift;
            end else begin
              if (act_q == bbs_pkg::ActRemove) begin
                count_q <= count_m1;
              end
              state_q <= StResp;
            end
          end else if (has_next) begin
            idx_q <= idx_nx_addr;
          end else begin
            state_q <= StResp;
          end
        end
        StShift: begin
          if (has_next) begin
            idx_q <= idx_nx_addr;
          end else begin
            count_q <= count_m1;
            state_q <= StResp;
          end
        end
        StResp: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Item capture, pending result fields and the output register.
  always_ff @(posedge clk_i) begin
    if (item_fire) begin
      act_q <= item_i.action;
      val_q <= item_i.value;
    end
    case (state_q)
      StExec: begin
        res_status_q <= bbs_pkg::StOk;
        res_found_q  <= 1'b0;
        res_data_q   <= '0;
        if (act_q == bbs_pkg::ActPush && is_full) begin
          res_status_q <= bbs_pkg::StFull;
        end
        if ((act_q == bbs_pkg::ActTop || act_q == bbs_pkg::ActPop) && is_zero) begin
          res_status_q <= bbs_pkg::StEmpty;
        end
      end
      StTopWait: begin
        res_data_q <= rdata_q;
      end
      StScan: begin
        if (match) begin
          res_found_q <= 1'b1;
          if (act_q == bbs_pkg::ActContains) begin
            res_data_q <= rdata_q;
          end
        end
      end
      StResp: begin
        if (out_free) begin
          out_status_q <= res_status_q;
          out_found_q  <= res_found_q;
          out_data_q   <= res_data_q;
          out_fill_q   <= FillW'(count_q);
          out_empty_q  <= is_zero;
        end
      end
      default: ;
    endcase
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.status     = out_status_q;
  assign result_o.found      = out_found_q;
  assign result_o.data       = out_data_q;
  assign result_o.fill_count = out_fill_q;
  assign result_o.is_empty   = out_empty_q;

endmodule
